/* rtl/mbs_pkg.sv */
// shared types, constants and register codes for the mppt bisection stride block
package mbs_pkg;

  localparam int VOLT_W   = 20;
  localparam int POWER_W  = 40;
  localparam int REGION_W = 2;
  localparam int CFG_DW   = 64;
  localparam int CFG_AW   = 5;

  localparam int MUL_MC_W   = 40;
  localparam int MUL_MP_W   = 20;
  localparam int MUL_PROD_W = MUL_MC_W + MUL_MP_W;
  localparam int MUL_STEPS  = MUL_MP_W;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS);

  localparam int DIV_N_W   = 40;
  localparam int DIV_D_W   = 20;
  localparam int DIV_STEPS = DIV_N_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int FRAC_BITS = 12;

  localparam logic [VOLT_W-1:0]  STRIDE_MAX          = '1;
  localparam logic [VOLT_W-1:0]  RST_MIN_STRIDE      = 20'd41;
  localparam logic [VOLT_W-1:0]  RST_SLOPE_MULT      = 20'd4096;
  localparam logic [POWER_W-1:0] RST_MIN_POWER_DELTA = 40'd167772;
  localparam logic [VOLT_W-1:0]  RST_MIN_VOLT_DELTA  = 20'd4;

  localparam logic [REGION_W-1:0] REGION_FLAT  = 2'd0;
  localparam logic [REGION_W-1:0] REGION_RIGHT = 2'd1;
  localparam logic [REGION_W-1:0] REGION_LEFT  = 2'd2;

  typedef enum logic [1:0] {
    CFG_MIN_STRIDE        = 2'd0,
    CFG_SLOPE_MULT        = 2'd1,
    CFG_MIN_POWER_DELTA   = 2'd2,
    CFG_MIN_VOLTAGE_DELTA = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_EVAL,
    ST_DECIDE,
    ST_DIV,
    ST_MUL_S,
    ST_DONE
  } state_t;

endpackage

/* rtl/mppt_bisection_stride_core.sv */
// top level of the mppt bisection stride generator
//
// input channel: in_voltage / in_current (unsigned Q8.12), taken when in_valid is
// high and in_stall is low. in_stall is high for the whole time one transaction
// is being worked on, so one sample is handled at a time.
// result channel: out_stride (Q8.12 volts) and out_region, held in an output
// register; out_valid stays high until the receiver drops out_stall.
// the time per sample is set by the serial units: a shift-add multiply for
// power on every sample and, on the positive-slope path only, a restoring
// divide for |dP|/|dV| and a second multiply by the slope multiplier, all
// one bit per cycle. the next sample is accepted only after the previous
// result has been loaded into the output register.
// a new sample may be accepted while the previous result still waits in the
// output register; if it is still waiting when the next result is ready, the
// block holds that result until out_stall drops.
// reset (rst_n low, synchronous) clears the previous sample to zero, loads the
// register defaults and empties the output register. the apb-style config port
// at byte addresses 8*i must be written only while idle; the block won't check.
module mppt_bisection_stride_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mbs_pkg::VOLT_W-1:0]     in_voltage,
  input  logic [mbs_pkg::VOLT_W-1:0]     in_current,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mbs_pkg::VOLT_W-1:0]     out_stride,
  output logic [mbs_pkg::REGION_W-1:0]   out_region,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbs_pkg::CFG_AW-1:0]     paddr,
  input  logic [mbs_pkg::CFG_DW-1:0]     pwdata,
  output logic [mbs_pkg::CFG_DW-1:0]     prdata,
  output logic                           pready
);
  import mbs_pkg::*;

  state_t state_r, state_nxt;

  // config registers
  logic [VOLT_W-1:0]  min_stride_r;
  logic [VOLT_W-1:0]  slope_mult_r;
  logic [POWER_W-1:0] min_pd_r;
  logic [VOLT_W-1:0]  min_vd_r;
  cfg_idx_t           cfg_idx;

  // previous sample
  logic [VOLT_W-1:0]  last_v_r, last_v_nxt;
  logic [POWER_W-1:0] last_p_r, last_p_nxt;

  // current sample working registers
  logic [VOLT_W-1:0]   v_r, v_nxt;
  logic [POWER_W-1:0]  p_r, p_nxt;
  logic [VOLT_W-1:0]   adv_r, adv_nxt;
  logic [POWER_W-1:0]  adp_r, adp_nxt;
  logic                dv_neg_r, dv_neg_nxt;
  logic                dp_neg_r, dp_neg_nxt;
  logic [VOLT_W-1:0]   step_r, step_nxt;
  logic [REGION_W-1:0] region_r, region_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [VOLT_W-1:0]   out_stride_r, out_stride_nxt;
  logic [REGION_W-1:0] out_region_r, out_region_nxt;

  // serial units
  logic                  mul_start;
  logic [MUL_MC_W-1:0]   mul_mcand;
  logic [MUL_MP_W-1:0]   mul_mplier;
  logic [MUL_PROD_W-1:0] mul_prod;
  logic                  mul_done;
  logic                  div_start;
  logic [DIV_N_W-1:0]    div_quot;
  logic                  div_done;

  // deltas, both directions in parallel, borrow picks the sign
  logic [VOLT_W:0]  vdiff, vdiff_n;
  logic [POWER_W:0] pdiff, pdiff_n;
  logic             thr_ok;

  assign vdiff   = {1'b0, v_r} - {1'b0, last_v_r};
  assign vdiff_n = {1'b0, last_v_r} - {1'b0, v_r};
  assign pdiff   = {1'b0, p_r} - {1'b0, last_p_r};
  assign pdiff_n = {1'b0, last_p_r} - {1'b0, p_r};

  // both deltas reach their thresholds and power actually moved
  assign thr_ok = (adp_r >= min_pd_r) && (adv_r >= min_vd_r) && (adp_r != '0);

  mbs_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .prod   (mul_prod),
    .done   (mul_done)
  );

  mbs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (adp_r),
    .divisor  (adv_r),
    .quotient (div_quot),
    .done     (div_done)
  );

  always_comb begin
    state_nxt      = state_r;
    last_v_nxt     = last_v_r;
    last_p_nxt     = last_p_r;
    v_nxt          = v_r;
    p_nxt          = p_r;
    adv_nxt        = adv_r;
    adp_nxt        = adp_r;
    dv_neg_nxt     = dv_neg_r;
    dp_neg_nxt     = dp_neg_r;
    step_nxt       = step_r;
    region_nxt     = region_r;
    out_valid_nxt  = out_valid_r;
    out_stride_nxt = out_stride_r;
    out_region_nxt = out_region_r;
    mul_start      = 1'b0;
    mul_mcand      = '0;
    mul_mplier     = '0;
    div_start      = 1'b0;

    // receiver takes the waiting result
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // power = voltage * current
          mul_start  = 1'b1;
          mul_mcand  = {{(MUL_MC_W-VOLT_W){1'b0}}, in_voltage};
          mul_mplier = in_current;
          v_nxt      = in_voltage;
          state_nxt  = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        if (mul_done) begin
          p_nxt     = mul_prod[POWER_W-1:0];
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        dv_neg_nxt = vdiff[VOLT_W];
        adv_nxt    = vdiff[VOLT_W] ? vdiff_n[VOLT_W-1:0] : vdiff[VOLT_W-1:0];
        dp_neg_nxt = pdiff[POWER_W];
        adp_nxt    = pdiff[POWER_W] ? pdiff_n[POWER_W-1:0] : pdiff[POWER_W-1:0];
        // sample becomes the previous one on every transaction
        last_v_nxt = v_r;
        last_p_nxt = p_r;
        state_nxt  = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = ST_DONE;
        priority if (!thr_ok) begin
          region_nxt = REGION_FLAT;
          step_nxt   = '0;
        end else if ((dv_neg_r != dp_neg_r) && (adv_r != '0)) begin
          // negative slope: bisection step
          region_nxt = REGION_RIGHT;
          step_nxt   = {1'b0, adv_r[VOLT_W-1:1]};
        end else if (adv_r == '0) begin
          // vertical slope, sign of dP decides
          if (dp_neg_r) begin
            region_nxt = REGION_RIGHT;
            step_nxt   = '0;
          end else begin
            region_nxt = REGION_LEFT;
            step_nxt   = STRIDE_MAX;
          end
        end else begin
          // positive slope: |dP| / |dV| then gain
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mul_start  = 1'b1;
          mul_mcand  = div_quot;
          mul_mplier = slope_mult_r;
          state_nxt  = ST_MUL_S;
        end
      end
      ST_MUL_S: begin
        if (mul_done) begin
          region_nxt = REGION_LEFT;
          // drop the fraction, saturate anything at or above 2^20
          if (mul_prod[MUL_PROD_W-1:FRAC_BITS+VOLT_W] != '0) begin
            step_nxt = STRIDE_MAX;
          end else begin
            step_nxt = mul_prod[FRAC_BITS+VOLT_W-1:FRAC_BITS];
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_stride_nxt = (step_r > min_stride_r) ? step_r : min_stride_r;
          out_region_nxt = region_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_v_r    <= '0;
      last_p_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_v_r    <= last_v_nxt;
      last_p_r    <= last_p_nxt;
      out_valid_r <= out_valid_nxt;
    end
    v_r          <= v_nxt;
    p_r          <= p_nxt;
    adv_r        <= adv_nxt;
    adp_r        <= adp_nxt;
    dv_neg_r     <= dv_neg_nxt;
    dp_neg_r     <= dp_neg_nxt;
    step_r       <= step_nxt;
    region_r     <= region_nxt;
    out_stride_r <= out_stride_nxt;
    out_region_r <= out_region_nxt;
  end

  // register file, 8-byte stride
  assign cfg_idx = cfg_idx_t'(paddr[CFG_AW-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_stride_r <= RST_MIN_STRIDE;
      slope_mult_r <= RST_SLOPE_MULT;
      min_pd_r     <= RST_MIN_POWER_DELTA;
      min_vd_r     <= RST_MIN_VOLT_DELTA;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_idx)
        CFG_MIN_STRIDE:        min_stride_r <= pwdata[VOLT_W-1:0];
        CFG_SLOPE_MULT:        slope_mult_r <= pwdata[VOLT_W-1:0];
        CFG_MIN_POWER_DELTA:   min_pd_r     <= pwdata[POWER_W-1:0];
        CFG_MIN_VOLTAGE_DELTA: min_vd_r     <= pwdata[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_MIN_STRIDE:        prdata = {{(CFG_DW-VOLT_W){1'b0}}, min_stride_r};
      CFG_SLOPE_MULT:        prdata = {{(CFG_DW-VOLT_W){1'b0}}, slope_mult_r};
      CFG_MIN_POWER_DELTA:   prdata = {{(CFG_DW-POWER_W){1'b0}}, min_pd_r};
      CFG_MIN_VOLTAGE_DELTA: prdata = {{(CFG_DW-VOLT_W){1'b0}}, min_vd_r};
      default:               prdata = '0;
    endcase
  end

  assign pready     = 1'b1;
  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_stride = out_stride_r;
  assign out_region = out_region_r;

endmodule

/* rtl/mbs_mul.sv */
// bit-serial shift-add multiplier, one multiplier bit per cycle
module mbs_mul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [mbs_pkg::MUL_MC_W-1:0]    mcand,
  input  logic [mbs_pkg::MUL_MP_W-1:0]    mplier,
  output logic [mbs_pkg::MUL_PROD_W-1:0]  prod,
  output logic                            done
);
  import mbs_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [MUL_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [MUL_PROD_W-1:0] acc_r, acc_nxt;
  logic [MUL_PROD_W-1:0] mc_r, mc_nxt;
  logic [MUL_MP_W-1:0]   mp_r, mp_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      mc_nxt   = {{MUL_MP_W{1'b0}}, mcand};
      mp_nxt   = mplier;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_nxt = acc_r + mc_r;
      end
      mc_nxt = {mc_r[MUL_PROD_W-2:0], 1'b0};
      mp_nxt = {1'b0, mp_r[MUL_MP_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(MUL_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

/* rtl/mbs_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module mbs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mbs_pkg::DIV_N_W-1:0]   dividend,
  input  logic [mbs_pkg::DIV_D_W-1:0]   divisor,
  output logic [mbs_pkg::DIV_N_W-1:0]   quotient,
  output logic                          done
);
  import mbs_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_N_W-1:0]   dq_r, dq_nxt;
  logic [DIV_D_W-1:0]   dvs_r, dvs_nxt;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W+1:0]   diff;
  logic                 ge;

  // partial remainder stays below the divisor, so the trial fits one extra bit
  assign trial = {rem_r, dq_r[DIV_N_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_r};
  assign ge    = ~diff[DIV_D_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dq_nxt   = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      dq_nxt  = {dq_r[DIV_N_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = dq_r;
  assign done     = done_r;

endmodule

/* rtl/mbs_checker.sv */
// port-level checker for the mppt bisection stride block, with its bind
module mbs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [mbs_pkg::VOLT_W-1:0]   out_stride,
  input logic [mbs_pkg::REGION_W-1:0] out_region,
  input logic                         pready
);
  import mbs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_stride) && $stable(out_region))
    else $error("result changed or dropped while stalled");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a transaction");

  // a result never shows up the cycle right after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // only the three defined region codes
  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_region == REGION_FLAT) || (out_region == REGION_RIGHT) ||
                  (out_region == REGION_LEFT))
    else $error("undefined region code");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind mppt_bisection_stride_core mbs_checker u_mbs_checker (.*);

/* tb/mbs_stride_checker.sv */
// checker that predicts and compares every stride transaction of the mppt stride core
`timescale 1ns / 100ps
module mbs_stride_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [mbs_pkg::VOLT_W-1:0]     in_voltage,
  input  logic [mbs_pkg::VOLT_W-1:0]     in_current,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [mbs_pkg::VOLT_W-1:0]     out_stride,
  input  logic [mbs_pkg::REGION_W-1:0]   out_region,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbs_pkg::CFG_AW-1:0]     paddr,
  input  logic [mbs_pkg::CFG_DW-1:0]     pwdata,
  input  logic [mbs_pkg::CFG_DW-1:0]     prdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             pending
);
  import mbs_pkg::*;

  localparam int PRINT_LIMIT = 50;

  typedef struct packed {
    logic [VOLT_W-1:0]   stride;
    logic [REGION_W-1:0] region;
  } stride_result_t;

  logic [VOLT_W-1:0]  min_stride_q;
  logic [VOLT_W-1:0]  slope_mult_q;
  logic [POWER_W-1:0] min_pdelta_q;
  logic [VOLT_W-1:0]  min_vdelta_q;
  logic [VOLT_W-1:0]  prev_voltage;
  logic [POWER_W-1:0] prev_power;
  stride_result_t     expected_strides[$];

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    if (fail_count < PRINT_LIMIT)
      $display("%0t: %s mismatch: saw %0h, predicted %0h", $time, what, seen, wanted);
    fail_count++;
  endtask

  // works out the stride for one sample and moves the sample into history
  function automatic stride_result_t predict_stride(input logic [VOLT_W-1:0] v,
                                                    input logic [VOLT_W-1:0] c);
    logic [POWER_W-1:0] power;
    logic [VOLT_W-1:0]  dv_mag;
    logic [POWER_W-1:0] dp_mag;
    logic               dv_down;
    logic               dp_down;
    logic [POWER_W-1:0] slope;
    logic [63:0]        scaled;
    logic [VOLT_W-1:0]  step;
    stride_result_t     res;
    power   = POWER_W'(v) * POWER_W'(c);
    dv_down = v < prev_voltage;
    dp_down = power < prev_power;
    dv_mag  = dv_down ? prev_voltage - v : v - prev_voltage;
    dp_mag  = dp_down ? prev_power - power : power - prev_power;
    step       = '0;
    res.region = REGION_FLAT;
    if (dp_mag != 0 && dp_mag >= min_pdelta_q && dv_mag >= min_vdelta_q) begin
      if (dv_mag == 0) begin
        // vertical slope, the sign of the power change alone decides
        if (dp_down) begin
          res.region = REGION_RIGHT;
        end else begin
          res.region = REGION_LEFT;
          step       = STRIDE_MAX;
        end
      end else if (dv_down != dp_down) begin
        res.region = REGION_RIGHT;
        step       = dv_mag >> 1;
      end else begin
        slope      = dp_mag / POWER_W'(dv_mag);
        scaled     = ({24'd0, slope} * {44'd0, slope_mult_q}) >> FRAC_BITS;
        res.region = REGION_LEFT;
        step       = (scaled > {44'd0, STRIDE_MAX}) ? STRIDE_MAX : scaled[VOLT_W-1:0];
      end
    end
    res.stride   = (step > min_stride_q) ? step : min_stride_q;
    prev_voltage = v;
    prev_power   = power;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    stride_result_t    want;
    logic [CFG_DW-1:0] reg_value;
    cfg_idx_t          idx;
    if (!rst_n) begin
      min_stride_q = RST_MIN_STRIDE;
      slope_mult_q = RST_SLOPE_MULT;
      min_pdelta_q = RST_MIN_POWER_DELTA;
      min_vdelta_q = RST_MIN_VOLT_DELTA;
      prev_voltage = '0;
      prev_power   = '0;
      expected_strides.delete();
    end else begin
      // results first, a sample taken at the same edge queues behind them
      if (out_valid && !out_stall) begin
        if (expected_strides.size() == 0) begin
          report_mismatch("unpredicted stride transaction", 64'(out_stride), '0);
        end else begin
          want = expected_strides.pop_front();
          if (out_stride !== want.stride)
            report_mismatch("stride", 64'(out_stride), 64'(want.stride));
          if (out_region !== want.region)
            report_mismatch("region", 64'(out_region), 64'(want.region));
        end
      end
      if (in_valid && !in_stall)
        expected_strides.push_back(predict_stride(in_voltage, in_current));
      if (psel && penable && pready) begin
        idx = cfg_idx_t'(paddr[CFG_AW-1:3]);
        if (pwrite) begin
          case (idx)
            CFG_MIN_STRIDE:      min_stride_q = pwdata[VOLT_W-1:0];
            CFG_SLOPE_MULT:      slope_mult_q = pwdata[VOLT_W-1:0];
            CFG_MIN_POWER_DELTA: min_pdelta_q = pwdata[POWER_W-1:0];
            default:             min_vdelta_q = pwdata[VOLT_W-1:0];
          endcase
        end else begin
          case (idx)
            CFG_MIN_STRIDE:      reg_value = CFG_DW'(min_stride_q);
            CFG_SLOPE_MULT:      reg_value = CFG_DW'(slope_mult_q);
            CFG_MIN_POWER_DELTA: reg_value = CFG_DW'(min_pdelta_q);
            default:             reg_value = CFG_DW'(min_vdelta_q);
          endcase
          if (prdata !== reg_value) report_mismatch("register read", prdata, reg_value);
        end
      end
    end
    pending = expected_strides.size();
  end

endmodule

/* tb/mppt_bisection_stride_core_tb.sv */
// testbench top: stimulus, flow control and verdict for the mppt stride core
`timescale 1ns / 100ps
module mppt_bisection_stride_core_tb;
  import mbs_pkg::*;

  // quiet cycles allowed before the run is declared hung; the slowest legal
  // stretch is the long receiver hold-off plus one slope-path sample
  localparam int WATCHDOG_LIMIT  = 4000;
  // settle time after the last result, comfortably above the slope path
  localparam int DRAIN_CYCLES    = 100;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_SAMPLES   = 80;
  localparam int RANDOM_PHASES   = 6;

  localparam logic [VOLT_W-1:0]  FIELD_MAX  = '1;
  localparam logic [POWER_W-1:0] PDELTA_MAX = '1;

  typedef enum logic [1:0] {
    RX_READY,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [VOLT_W-1:0]   in_voltage;
  logic [VOLT_W-1:0]   in_current;
  logic                out_valid;
  logic                out_stall;
  logic [VOLT_W-1:0]   out_stride;
  logic [REGION_W-1:0] out_region;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  int fail_count;
  int pending;

  // receiver behavior, set per phase by the stimulus process
  rx_mode_t rx_mode      = RX_READY;
  int       rx_stall_pct = 0;
  int       rx_period    = 1;
  int       rx_duty      = 0;
  int       hold_left    = 0;

  // sender behavior
  bit       gaps_on    = 1'b0;
  int       burst_left = 0;

  // last sample offered, the base of the random walk
  logic [VOLT_W-1:0] sent_voltage = '0;
  logic [VOLT_W-1:0] sent_current = '0;

  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mppt_bisection_stride_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_voltage (in_voltage),
    .in_current (in_current),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_stride (out_stride),
    .out_region (out_region),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  mbs_stride_checker stride_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_voltage (in_voltage),
    .in_current (in_current),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_stride (out_stride),
    .out_region (out_region),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // watchdog: any transaction on any port restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("mppt_bisection_stride_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: one out_stall update per falling edge; the long hold-off is
  // counted down here so the sender keeps pushing while results back up
  initial begin : receiver
    int tick;
    tick      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (rx_mode)
          RX_READY:  out_stall <= 1'b0;
          RX_RANDOM: out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
          default:   out_stall <= ((tick % rx_period) < rx_duty);
        endcase
      end
    end
  end

  // offer one sample, hold it until taken, then maybe leave a gap;
  // called and returns at a falling edge
  task automatic offer_sample(input logic [VOLT_W-1:0] v, input logic [VOLT_W-1:0] c);
    in_voltage   <= v;
    in_current   <= c;
    in_valid     <= 1'b1;
    sent_voltage  = v;
    sent_current  = c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        in_valid  <= 1'b0;
        // mostly short gaps, now and then a longer one, at times longer than the slope path
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(7, 120)) @(negedge clk);
        else repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // setup and access cycle of a write, then a read of the same register
  task automatic program_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] value);
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // half the time garbage rides above the register width and must be dropped
  function automatic logic [CFG_DW-1:0] with_junk(input logic [CFG_DW-1:0] value,
                                                  input int width);
    logic [CFG_DW-1:0] junk;
    junk = {$urandom(), $urandom()};
    if ($urandom_range(0, 1) == 0) junk = '0;
    return value | (junk & ~((64'd1 << width) - 64'd1));
  endfunction

  task automatic apply_settings(input logic [VOLT_W-1:0] stride_floor,
                                input logic [VOLT_W-1:0] gain,
                                input logic [POWER_W-1:0] pdelta,
                                input logic [VOLT_W-1:0] vdelta);
    program_reg(CFG_MIN_STRIDE, with_junk(CFG_DW'(stride_floor), VOLT_W));
    program_reg(CFG_SLOPE_MULT, with_junk(CFG_DW'(gain), VOLT_W));
    program_reg(CFG_MIN_POWER_DELTA, with_junk(CFG_DW'(pdelta), POWER_W));
    program_reg(CFG_MIN_VOLTAGE_DELTA, with_junk(CFG_DW'(vdelta), VOLT_W));
  endtask

  // stop sending, wait for every predicted result, then let the core settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [VOLT_W-1:0]  stride_floor;
    logic [VOLT_W-1:0]  gain;
    logic [POWER_W-1:0] pdelta;
    logic [VOLT_W-1:0]  vdelta;
    int                 span;
    int                 nv;
    int                 nc;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_voltage = '0;
    in_current = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset settings: zero change, saturated slope, both-down slope,
    // equal power, right side bisection, each threshold just missed, bit patterns
    offer_sample('0, '0);
    offer_sample(FIELD_MAX, FIELD_MAX);
    offer_sample(FIELD_MAX, FIELD_MAX);
    offer_sample('0, FIELD_MAX);
    offer_sample(20'd2048, 20'd4096);
    offer_sample(20'd4096, 20'd2048);
    offer_sample(20'd8192, 20'd512);
    offer_sample(20'd8194, 20'd512);
    offer_sample(20'd8200, 20'd513);
    offer_sample(20'hAAAAA, 20'h55555);
    offer_sample(20'h55555, 20'hAAAAA);
    offer_sample(20'd1, FIELD_MAX);
    offer_sample(FIELD_MAX, 20'd1);
    drain();

    // no thresholds, no floor, full gain: vertical slope up and down
    apply_settings('0, FIELD_MAX, '0, '0);
    offer_sample(20'd4096, 20'd4096);
    offer_sample(20'd4096, 20'd8192);
    offer_sample(20'd4096, 20'd2048);
    offer_sample(20'd4096, 20'd2048);
    offer_sample(20'd4100, 20'd2049);
    offer_sample(20'd4104, 20'd2048);
    drain();

    // every threshold at its top: nothing counts, stride pinned at the floor
    apply_settings(FIELD_MAX, '0, PDELTA_MAX, FIELD_MAX);
    offer_sample('0, '0);
    offer_sample(FIELD_MAX, FIELD_MAX);
    offer_sample(20'd12345, 20'd678);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: apply_settings('0, FIELD_MAX, '0, '0);
        1: apply_settings(FIELD_MAX, FIELD_MAX, PDELTA_MAX, FIELD_MAX);
        2: apply_settings(RST_MIN_STRIDE, RST_SLOPE_MULT, RST_MIN_POWER_DELTA,
                          RST_MIN_VOLT_DELTA);
        default: begin
          case ($urandom_range(0, 3))
            0:       stride_floor = '0;
            1:       stride_floor = VOLT_W'($urandom_range(0, 4095));
            2:       stride_floor = RST_MIN_STRIDE;
            default: stride_floor = VOLT_W'($urandom());
          endcase
          case ($urandom_range(0, 3))
            0:       gain = '0;
            1:       gain = RST_SLOPE_MULT;
            2:       gain = VOLT_W'($urandom_range(1, 16384));
            default: gain = VOLT_W'($urandom());
          endcase
          case ($urandom_range(0, 3))
            0:       pdelta = '0;
            1:       pdelta = RST_MIN_POWER_DELTA;
            2:       pdelta = POWER_W'($urandom_range(0, 1 << 24));
            default: pdelta = POWER_W'({$urandom(), $urandom()});
          endcase
          case ($urandom_range(0, 3))
            0:       vdelta = '0;
            1:       vdelta = RST_MIN_VOLT_DELTA;
            2:       vdelta = VOLT_W'($urandom_range(0, 255));
            default: vdelta = VOLT_W'($urandom());
          endcase
          apply_settings(stride_floor, gain, pdelta, vdelta);
        end
      endcase

      // flow control for this phase; the hold-off phase sends back to back
      gaps_on      = (ph != 2) && ($urandom_range(0, 2) != 0);
      burst_left   = 0;
      rx_stall_pct = $urandom_range(10, 90);
      rx_period    = $urandom_range(2, 12);
      rx_duty      = $urandom_range(1, rx_period - 1);
      case ($urandom_range(0, 2))
        0:       rx_mode = RX_READY;
        1:       rx_mode = RX_RANDOM;
        default: rx_mode = RX_PATTERN;
      endcase

      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        if (ph == 2 && n == 5) hold_left = HOLD_OFF_CYCLES;
        case ($urandom_range(0, 19))
          // walk along the curve in steps of widely varying size
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
            span = 1 << $urandom_range(0, 14);
            nv   = int'(sent_voltage) + int'($urandom_range(0, 2 * span)) - span;
            span = 1 << $urandom_range(0, 12);
            nc   = int'(sent_current) + int'($urandom_range(0, 2 * span)) - span;
            if (nv < 0) nv = 0;
            if (nv > int'(FIELD_MAX)) nv = int'(FIELD_MAX);
            if (nc < 0) nc = 0;
            if (nc > int'(FIELD_MAX)) nc = int'(FIELD_MAX);
            offer_sample(VOLT_W'(nv), VOLT_W'(nc));
          end
          12, 13, 14, 15: offer_sample(VOLT_W'($urandom()), VOLT_W'($urandom()));
          16, 17:         offer_sample(sent_voltage, sent_current);
          18:             offer_sample(sent_voltage, VOLT_W'($urandom()));
          default: begin
            offer_sample(($urandom_range(0, 1) == 0) ? '0 : FIELD_MAX,
                         ($urandom_range(0, 1) == 0) ? '0 : FIELD_MAX);
          end
        endcase
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("mppt_bisection_stride_core regression: pass");
    end else begin
      $display("mppt_bisection_stride_core regression: fail");
    end
    $finish;
  end

endmodule
